// ----- rtl/core/lhtp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhtp_pkg
// Types and constants shared by the LDP hello TLV parser modules.
// ----------------------------------------------------------------------------
package lhtp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [13:0] KIND_MASK         = 14'h3FFF;
  localparam logic [13:0] KIND_COMMON_HELLO = 14'h0400;
  localparam logic [13:0] KIND_TRANSPORT_V4 = 14'h0401;
  localparam logic [13:0] KIND_CFG_SEQNUM   = 14'h0402;
  localparam int unsigned T_FLAG_BIT        = 15;
  localparam int unsigned R_FLAG_BIT        = 14;
  localparam logic [15:0] MIN_VALUE_LEN     = 16'd4;
  localparam logic [2:0]  VALUE_BYTES       = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN   = 2'd1;
  localparam logic [1:0] STATUS_NO_COMMON = 2'd2;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_body;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] hold_time;
    logic        targeted;
    logic        req_targeted;
    logic [31:0] transport_addr;
    logic [31:0] cfg_seqnum;
  } result_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_BYTE_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } work_t;

endpackage

// ----- rtl/core/lhtp_front.sv -----
// ----------------------------------------------------------------------------
// lhtp_front
// Input stage: accepts items, drops empty non-final ones, tags the rest.
// ----------------------------------------------------------------------------
module lhtp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lhtp_pkg::item_t  item,
  output logic             work_valid,
  output lhtp_pkg::work_t  work,
  input  logic             work_full
);

  logic            valid;
  lhtp_pkg::work_t work_reg;
  logic            ready;
  logic            accept;
  logic            keep;
  lhtp_pkg::op_t   op;

  assign ready  = !valid || !work_full;
  assign full   = !ready;
  assign accept = push && ready;
  assign keep   = item.has_byte || item.end_of_body;

  always_comb begin
    if (item.has_byte && item.end_of_body) begin
      op = lhtp_pkg::OP_BYTE_END;
    end else if (item.end_of_body) begin
      op = lhtp_pkg::OP_END;
    end else begin
      op = lhtp_pkg::OP_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept && keep) begin
      valid <= 1'b1;
    end else if (!work_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      work_reg.op        <= op;
      work_reg.data_byte <= item.data_byte;
    end
  end

  assign work_valid = valid;
  assign work       = work_reg;

endmodule

// ----- rtl/core/lhtp_queue.sv -----
// ----------------------------------------------------------------------------
// lhtp_queue
// Small FIFO of tagged beats between the front and the TLV walker.
// ----------------------------------------------------------------------------
module lhtp_queue #(
  parameter int unsigned DEPTH = lhtp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  lhtp_pkg::work_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output lhtp_pkg::work_t rd_data,
  output logic            empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lhtp_pkg::work_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/lhtp_walker.sv -----
// ----------------------------------------------------------------------------
// lhtp_walker
// TLV walker: header/value tracking, captures, and the result register.
// ----------------------------------------------------------------------------
module lhtp_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              work_valid,
  input  lhtp_pkg::work_t   work,
  output logic              work_take,
  output logic              empty,
  input  logic              pop,
  output lhtp_pkg::result_t result
);

  logic        in_value,        in_value_next;
  logic [1:0]  header_count,    header_count_next;
  logic [23:0] header_shift,    header_shift_next;
  logic [13:0] tlv_kind,        tlv_kind_next;
  logic        tlv_long_enough, tlv_long_enough_next;
  logic [15:0] value_remaining, value_remaining_next;
  logic [2:0]  value_index,     value_index_next;
  logic [31:0] value_shift,     value_shift_next;
  logic [15:0] saved_hold_time, saved_hold_time_next;
  logic [1:0]  saved_flags,     saved_flags_next;
  logic [31:0] saved_transport, saved_transport_next;
  logic [31:0] saved_cfg_seqnum, saved_cfg_seqnum_next;
  logic        seen_common,     seen_common_next;

  logic              res_valid;
  lhtp_pkg::result_t res_reg;
  lhtp_pkg::result_t res_next;
  logic              has_byte;
  logic              is_end;
  logic [7:0]        b;
  logic [15:0]       len;

  assign has_byte = work.op == lhtp_pkg::OP_BYTE || work.op == lhtp_pkg::OP_BYTE_END;
  assign is_end   = work.op == lhtp_pkg::OP_END || work.op == lhtp_pkg::OP_BYTE_END;
  assign b        = work.data_byte;
  assign len      = {header_shift[7:0], b};

  // an end beat needs the result slot free (or being popped this cycle)
  assign work_take = work_valid && (!is_end || !res_valid || pop);

  always_comb begin
    in_value_next         = in_value;
    header_count_next     = header_count;
    header_shift_next     = header_shift;
    tlv_kind_next         = tlv_kind;
    tlv_long_enough_next  = tlv_long_enough;
    value_remaining_next  = value_remaining;
    value_index_next      = value_index;
    value_shift_next      = value_shift;
    saved_hold_time_next  = saved_hold_time;
    saved_flags_next      = saved_flags;
    saved_transport_next  = saved_transport;
    saved_cfg_seqnum_next = saved_cfg_seqnum;
    seen_common_next      = seen_common;

    if (has_byte) begin
      if (!in_value) begin
        if (header_count != 2'd3) begin
          header_shift_next = {header_shift[15:0], b};
          header_count_next = header_count + 2'd1;
        end else begin
          tlv_kind_next        = header_shift[21:8] & lhtp_pkg::KIND_MASK;
          tlv_long_enough_next = len >= lhtp_pkg::MIN_VALUE_LEN;
          value_remaining_next = len;
          value_index_next     = '0;
          value_shift_next     = '0;
          header_count_next    = '0;
          header_shift_next    = '0;
          in_value_next        = len != 16'd0;
        end
      end else begin
        if (value_index < lhtp_pkg::VALUE_BYTES) begin
          value_shift_next = {value_shift[23:0], b};
          value_index_next = value_index + 3'd1;
          if (value_index == lhtp_pkg::VALUE_BYTES - 3'd1 && tlv_long_enough) begin
            if (tlv_kind == lhtp_pkg::KIND_COMMON_HELLO) begin
              saved_hold_time_next = value_shift_next[31:16];
              saved_flags_next     = {value_shift_next[lhtp_pkg::T_FLAG_BIT],
                                      value_shift_next[lhtp_pkg::R_FLAG_BIT]};
              seen_common_next     = 1'b1;
            end else if (tlv_kind == lhtp_pkg::KIND_TRANSPORT_V4) begin
              saved_transport_next = value_shift_next;
            end else if (tlv_kind == lhtp_pkg::KIND_CFG_SEQNUM) begin
              saved_cfg_seqnum_next = value_shift_next;
            end
          end
        end
        if (value_remaining != 16'd0) begin
          value_remaining_next = value_remaining - 16'd1;
        end
        if (value_remaining_next == 16'd0) begin
          in_value_next = 1'b0;
        end
      end
    end

    res_next = '0;
    if (in_value_next && value_remaining_next != 16'd0) begin
      res_next.status = lhtp_pkg::STATUS_OVERRUN;
    end else if (!seen_common_next) begin
      res_next.status = lhtp_pkg::STATUS_NO_COMMON;
    end else begin
      res_next.status         = lhtp_pkg::STATUS_OK;
      res_next.hold_time      = saved_hold_time_next;
      res_next.targeted       = saved_flags_next[1];
      res_next.req_targeted   = saved_flags_next[0];
      res_next.transport_addr = saved_transport_next;
      res_next.cfg_seqnum     = saved_cfg_seqnum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value         <= 1'b0;
      header_count     <= '0;
      header_shift     <= '0;
      tlv_kind         <= '0;
      tlv_long_enough  <= 1'b0;
      value_remaining  <= '0;
      value_index      <= '0;
      value_shift      <= '0;
      saved_hold_time  <= '0;
      saved_flags      <= '0;
      saved_transport  <= '0;
      saved_cfg_seqnum <= '0;
      seen_common      <= 1'b0;
    end else if (work_take) begin
      if (is_end) begin
        // body done: start clean for the next one
        in_value         <= 1'b0;
        header_count     <= '0;
        header_shift     <= '0;
        tlv_kind         <= '0;
        tlv_long_enough  <= 1'b0;
        value_remaining  <= '0;
        value_index      <= '0;
        value_shift      <= '0;
        saved_hold_time  <= '0;
        saved_flags      <= '0;
        saved_transport  <= '0;
        saved_cfg_seqnum <= '0;
        seen_common      <= 1'b0;
      end else begin
        in_value         <= in_value_next;
        header_count     <= header_count_next;
        header_shift     <= header_shift_next;
        tlv_kind         <= tlv_kind_next;
        tlv_long_enough  <= tlv_long_enough_next;
        value_remaining  <= value_remaining_next;
        value_index      <= value_index_next;
        value_shift      <= value_shift_next;
        saved_hold_time  <= saved_hold_time_next;
        saved_flags      <= saved_flags_next;
        saved_transport  <= saved_transport_next;
        saved_cfg_seqnum <= saved_cfg_seqnum_next;
        seen_common      <= seen_common_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (work_take && is_end) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_take && is_end) begin
      res_reg <= res_next;
    end
  end

  assign empty  = !res_valid;
  assign result = res_reg;

endmodule

// ----- rtl/core/ldp_hello_tlv_parser_top.sv -----
// ----------------------------------------------------------------------------
// ldp_hello_tlv_parser_top
// Walks LDP hello message body TLVs byte by byte; one result per body.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  item     | push / full        | has_byte, data_byte, end_of_body
//  result   | empty / pop        | status, hold_time, T, R, transport, seq
//
// One beat per cycle while full is low; the TLV walker updates its state once
// per byte. A result passes through the front register, the queue and the
// result register after its end beat is accepted. Synchronous reset
// clears all control state and captures. A waiting result holds the walker at
// the next end beat; input is still accepted until the queue and the front
// register fill.
//
module ldp_hello_tlv_parser_top #(
  parameter int unsigned QUEUE_DEPTH = lhtp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  lhtp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output lhtp_pkg::result_t result
);

  logic            fr_valid;
  lhtp_pkg::work_t fr_work;
  logic            q_full;
  logic            q_empty;
  lhtp_pkg::work_t q_head;
  logic            q_take;

  lhtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .work_valid (fr_valid),
    .work       (fr_work),
    .work_full  (q_full)
  );

  lhtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_valid),
    .wr_data (fr_work),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  lhtp_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .work_valid (!q_empty),
    .work       (q_head),
    .work_take  (q_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
